### design/pbe_pkg.sv
// Shared constants, types and helper functions of the piecewise Bezier evaluator.
package pbe_pkg;

    // Block configuration
    localparam int MAX_POINTS  = 256;
    localparam int ORDER       = 3;
    localparam int COORD_WIDTH = 16;

    // Fixed field widths
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 9;
    localparam int IDX_W     = 8;
    localparam int FIELD_W   = 16;
    localparam int POS_W     = 24;
    localparam int OUT_W     = 16;
    localparam int SEG_W     = 8;

    // Derived widths
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CMAX_W  = $clog2(MAX_POINTS + 1);
    localparam int N_W     = (CMAX_W > CNT_W) ? CMAX_W : CNT_W;
    localparam int IDXC_W  = (CMAX_W > IDX_W) ? CMAX_W : IDX_W;
    localparam int STEP_W  = $clog2(ORDER + 2);
    localparam int EXT_W   = $clog2(MAX_POINTS + ORDER + 1);
    localparam int I_W     = $clog2(ORDER + 1);
    localparam int BIN_W   = ORDER + 1;
    localparam int SPOW_W  = FRAC_BITS * ORDER;
    localparam int W_W     = SPOW_W + BIN_W;
    localparam int T_W     = FRAC_BITS + 1;
    localparam int SH      = SPOW_W;
    localparam int ACC_W   = COORD_WIDTH + SH + 1;
    localparam int RAM_W   = 2 * COORD_WIDTH;

    // Reciprocals for the count split: floor(x/d) is (x*RCP)>>RCP_SH or one more
    localparam int RCP_SH = N_W;
    localparam int RCP_W  = N_W + 1;
    localparam logic [RCP_W-1:0] RCP_M  = RCP_W'((1 << RCP_SH) / ORDER);
    localparam logic [RCP_W-1:0] RCP_M1 = RCP_W'((1 << RCP_SH) / (ORDER + 1));

    localparam logic [I_W-1:0] I_LAST = I_W'(ORDER);

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef logic [ORDER:0][BIN_W-1:0] t_binom_row;

    // Row ORDER of Pascal's triangle
    function automatic t_binom_row binom_row();
        int row [ORDER+1];
        t_binom_row res;
        for (int j = 0; j <= ORDER; j++) begin
            row[j] = (j == 0) ? 1 : 0;
        end
        for (int r = 1; r <= ORDER; r++) begin
            for (int j = ORDER; j >= 1; j--) begin
                if (j <= r) begin
                    row[j] = row[j] + row[j-1];
                end
            end
        end
        for (int j = 0; j <= ORDER; j++) begin
            res[j] = BIN_W'(row[j]);
        end
        return res;
    endfunction

    localparam t_binom_row BINOM = binom_row();

    // Sign-extend a coordinate field, then wrap to the stored width
    function automatic logic [COORD_WIDTH-1:0] coord_wrap(input logic signed [FIELD_W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[COORD_WIDTH-1:0];
    endfunction

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DIV    = 11'b000_0000_0010,
        S_LAYOUT = 11'b000_0000_0100,
        S_SPLIT  = 11'b000_0000_1000,
        S_BASE   = 11'b000_0001_0000,
        S_READ   = 11'b000_0010_0000,
        S_MUL    = 11'b000_0100_0000,
        S_ADD    = 11'b000_1000_0000,
        S_ABS    = 11'b001_0000_0000,
        S_RND    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

endpackage

### design/pbe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/piecewise_bezier_evaluator.sv
// Top level of the piecewise Bezier evaluator: control sequencer, MAC datapath, output word.
//
// The block holds up to MAX_POINTS 2-D control points in one RAM and evaluates a chain
// of Bezier segments of order ORDER over the first point_count of them. A write word
// (cmd 0) stores one point in the cycle it is accepted and produces no result. An
// evaluate word (cmd 1) wraps curve_pos to its 16-bit fraction u, chooses the connected
// layout (count-1 a multiple of ORDER, but not equal to ORDER) or else the separated
// layout (count a multiple of ORDER+1), picks segment floor(u*segments) and returns the
// exact Bernstein sum at the sub-position, rounded half away from zero. A count that fits
// no layout returns zero coordinates, segment 0 and bad_count set. Evaluation runs one word
// at a time: setup (divide, layout, split, base address, first read), then for each control
// point a RAM read and a Horner-style multiply-accumulate with separate x and y multipliers,
// then abs, rounding and output load. The input stalls until the sequencer is idle again; a
// bad count skips to output load and a write word leaves it idle. The output register
// decouples the sides: the next word is accepted while a result waits to be taken, and
// the sequencer waits in its last state only if a second result is ready before the first
// has left. point_count is written through the cfg port while the sequencer is idle.
// Store entries are undefined until written.
module piecewise_bezier_evaluator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pbe_pkg::CNT_W-1:0]              i_cfg_data,
    // input words
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_cmd,
    input  logic [pbe_pkg::IDX_W-1:0]              i_point_index,
    input  logic signed [pbe_pkg::FIELD_W-1:0]     i_point_x,
    input  logic signed [pbe_pkg::FIELD_W-1:0]     i_point_y,
    input  logic signed [pbe_pkg::POS_W-1:0]       i_curve_pos,
    // result words
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [pbe_pkg::OUT_W-1:0]       o_curve_x,
    output logic signed [pbe_pkg::OUT_W-1:0]       o_curve_y,
    output logic [pbe_pkg::SEG_W-1:0]              o_segment_index,
    output logic                                   o_bad_count
);

    import pbe_pkg::*;

    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (SH - 1);

    // ---------------------------------------------------------------- registers
    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_point_count;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_x, r_out_y;
    logic [SEG_W-1:0]           r_out_seg;
    logic                       r_out_bad;

    logic [FRAC_BITS-1:0]       r_u, n_u;
    logic [N_W-1:0]             r_qm, n_qm;      // raw quotient by ORDER
    logic [N_W-1:0]             r_qp, n_qp;      // raw quotient by ORDER+1
    logic [N_W-1:0]             r_segs, n_segs;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [N_W-1:0]             r_seg, n_seg;
    logic [FRAC_BITS-1:0]       r_s, n_s;
    logic [T_W-1:0]             r_t, n_t;
    logic [EXT_W-1:0]           r_addr, n_addr;
    logic [I_W-1:0]             r_i, n_i;
    logic [SPOW_W-1:0]          r_spow, n_spow;  // s^i
    logic [W_W-1:0]             r_w, n_w;        // C(ORDER,i) * s^i
    logic signed [ACC_W-1:0]    r_acc_x, n_acc_x;
    logic signed [ACC_W-1:0]    r_acc_y, n_acc_y;
    logic                       r_neg_x, n_neg_x;
    logic                       r_neg_y, n_neg_y;
    logic [OUT_W-1:0]           r_res_x, n_res_x;
    logic [OUT_W-1:0]           r_res_y, n_res_y;
    logic                       r_bad, n_bad;

    // ---------------------------------------------------------------- datapath wires
    logic                       in_accept, out_take, out_load;
    logic                       ram_we, ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [RAM_W-1:0]           ram_wdata, ram_rdata;
    logic signed [COORD_WIDTH-1:0] rd_x, rd_y;

    logic [N_W-1:0]             cnt_n, cnt_m1;
    logic [N_W+RCP_W-1:0]       prod_m, prod_p;
    logic [N_W-1:0]             rem_m0, rem_p0, rem_m, rem_p, quo_m, quo_p;
    logic                       cnt_ok, lay_conn, lay_sep;
    logic [FRAC_BITS+N_W-1:0]   prod_pos;
    logic [N_W+STEP_W-1:0]      prod_base;
    logic [W_W-1:0]             prod_w;
    logic signed [ACC_W+T_W:0]  prod_tx, prod_ty;
    logic signed [W_W+COORD_WIDTH:0] term_x, term_y;
    logic [SPOW_W+FRAC_BITS-1:0] prod_s;
    logic [ACC_W:0]             sum_x, sum_y, shf_x, shf_y;
    logic [OUT_W-1:0]           res_x, res_y;

    // ---------------------------------------------------------------- handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------- point store
    // Writes happen only in idle, reads only outside it: no same-entry overlap.
    assign ram_we    = in_accept && (i_cmd == CMD_WRITE) &&
                       (IDXC_W'(i_point_index) < IDXC_W'(MAX_POINTS));
    assign ram_wdata = {coord_wrap(i_point_x), coord_wrap(i_point_y)};
    assign ram_re    = (r_state == S_READ) || ((r_state == S_ADD) && (r_i != I_LAST));
    assign ram_raddr = (r_state == S_ADD) ? ADDR_W'(r_addr + EXT_W'(1)) : ADDR_W'(r_addr);

    pbe_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_point_index)),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = $signed(ram_rdata[RAM_W-1:COORD_WIDTH]);
    assign rd_y = $signed(ram_rdata[COORD_WIDTH-1:0]);

    // ---------------------------------------------------------------- layout decode
    // Quotients by reciprocal, then one correcting compare and subtract.
    assign cnt_n   = N_W'(r_point_count);
    assign cnt_m1  = cnt_n - N_W'(1);
    assign prod_m  = (N_W + RCP_W)'(cnt_m1) * (N_W + RCP_W)'(RCP_M);
    assign prod_p  = (N_W + RCP_W)'(cnt_n) * (N_W + RCP_W)'(RCP_M1);

    assign rem_m0  = cnt_m1 - N_W'(r_qm * N_W'(ORDER));
    assign rem_p0  = cnt_n - N_W'(r_qp * N_W'(ORDER + 1));
    assign quo_m   = (rem_m0 >= N_W'(ORDER)) ? r_qm + N_W'(1) : r_qm;
    assign rem_m   = (rem_m0 >= N_W'(ORDER)) ? rem_m0 - N_W'(ORDER) : rem_m0;
    assign quo_p   = (rem_p0 >= N_W'(ORDER + 1)) ? r_qp + N_W'(1) : r_qp;
    assign rem_p   = (rem_p0 >= N_W'(ORDER + 1)) ? rem_p0 - N_W'(ORDER + 1) : rem_p0;

    assign cnt_ok   = (cnt_n != '0) && (cnt_n <= N_W'(MAX_POINTS));
    assign lay_conn = cnt_ok && (cnt_m1 != N_W'(ORDER)) && (rem_m == '0);
    assign lay_sep  = cnt_ok && (rem_p == '0);

    // ---------------------------------------------------------------- arithmetic
    assign prod_pos  = (FRAC_BITS + N_W)'(r_u) * (FRAC_BITS + N_W)'(r_segs);
    assign prod_base = (N_W + STEP_W)'(r_seg) * (N_W + STEP_W)'(r_step);
    assign prod_w    = W_W'(BINOM[r_i]) * W_W'(r_spow);
    assign prod_tx   = r_acc_x * $signed({1'b0, r_t});
    assign prod_ty   = r_acc_y * $signed({1'b0, r_t});
    assign term_x    = $signed({1'b0, r_w}) * rd_x;
    assign term_y    = $signed({1'b0, r_w}) * rd_y;
    assign prod_s    = (SPOW_W + FRAC_BITS)'(r_spow) * (SPOW_W + FRAC_BITS)'(r_s);

    // r_acc holds magnitudes once past the abs step
    assign sum_x = {1'b0, r_acc_x} + HALF;
    assign sum_y = {1'b0, r_acc_y} + HALF;
    assign shf_x = sum_x >> SH;
    assign shf_y = sum_y >> SH;
    assign res_x = r_neg_x ? OUT_W'(-shf_x[OUT_W-1:0]) : shf_x[OUT_W-1:0];
    assign res_y = r_neg_y ? OUT_W'(-shf_y[OUT_W-1:0]) : shf_y[OUT_W-1:0];

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_qm    = r_qm;
        n_qp    = r_qp;
        n_segs  = r_segs;
        n_step  = r_step;
        n_seg   = r_seg;
        n_s     = r_s;
        n_t     = r_t;
        n_addr  = r_addr;
        n_i     = r_i;
        n_spow  = r_spow;
        n_w     = r_w;
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_neg_x = r_neg_x;
        n_neg_y = r_neg_y;
        n_res_x = r_res_x;
        n_res_y = r_res_y;
        n_bad   = r_bad;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_cmd == CMD_EVAL)) begin
                    n_u     = i_curve_pos[FRAC_BITS-1:0];
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_qm    = prod_m[N_W+RCP_SH-1:RCP_SH];
                n_qp    = prod_p[N_W+RCP_SH-1:RCP_SH];
                n_state = S_LAYOUT;
            end
            S_LAYOUT: begin
                priority if (lay_conn && (quo_m != '0)) begin
                    n_segs  = quo_m;
                    n_step  = STEP_W'(ORDER);
                    n_state = S_SPLIT;
                end else if (lay_sep && (quo_p != '0)) begin
                    n_segs  = quo_p;
                    n_step  = STEP_W'(ORDER + 1);
                    n_state = S_SPLIT;
                end else begin
                    // no usable layout
                    n_res_x = '0;
                    n_res_y = '0;
                    n_seg   = '0;
                    n_bad   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SPLIT: begin
                n_seg   = prod_pos[FRAC_BITS+N_W-1:FRAC_BITS];
                n_s     = prod_pos[FRAC_BITS-1:0];
                n_t     = T_W'(1 << FRAC_BITS) - T_W'(prod_pos[FRAC_BITS-1:0]);
                n_state = S_BASE;
            end
            S_BASE: begin
                n_addr  = EXT_W'(prod_base);
                n_i     = '0;
                n_spow  = SPOW_W'(1);
                n_acc_x = '0;
                n_acc_y = '0;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                // point i data arrives from the store this cycle
                n_w     = prod_w;
                n_acc_x = $signed(prod_tx[ACC_W-1:0]);
                n_acc_y = $signed(prod_ty[ACC_W-1:0]);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_acc_x = r_acc_x + $signed(term_x[ACC_W-1:0]);
                n_acc_y = r_acc_y + $signed(term_y[ACC_W-1:0]);
                n_spow  = prod_s[SPOW_W-1:0];
                if (r_i == I_LAST) begin
                    n_state = S_ABS;
                end else begin
                    n_i     = r_i + I_W'(1);
                    n_addr  = r_addr + EXT_W'(1);
                    n_state = S_MUL;
                end
            end
            S_ABS: begin
                n_neg_x = r_acc_x[ACC_W-1];
                n_neg_y = r_acc_y[ACC_W-1];
                n_acc_x = r_acc_x[ACC_W-1] ? -r_acc_x : r_acc_x;
                n_acc_y = r_acc_y[ACC_W-1] ? -r_acc_y : r_acc_y;
                n_state = S_RND;
            end
            S_RND: begin
                n_res_x = res_x;
                n_res_y = res_y;
                n_bad   = 1'b0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        r_u     <= n_u;
        r_qm    <= n_qm;
        r_qp    <= n_qp;
        r_segs  <= n_segs;
        r_step  <= n_step;
        r_seg   <= n_seg;
        r_s     <= n_s;
        r_t     <= n_t;
        r_addr  <= n_addr;
        r_i     <= n_i;
        r_spow  <= n_spow;
        r_w     <= n_w;
        r_acc_x <= n_acc_x;
        r_acc_y <= n_acc_y;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_res_x <= n_res_x;
        r_res_y <= n_res_y;
        r_bad   <= n_bad;
        if (out_load) begin
            r_out_x   <= r_res_x;
            r_out_y   <= r_res_y;
            r_out_seg <= r_seg[SEG_W-1:0];
            r_out_bad <= r_bad;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_curve_x       = $signed(r_out_x);
    assign o_curve_y       = $signed(r_out_y);
    assign o_segment_index = r_out_seg;
    assign o_bad_count     = r_out_bad;

    // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
    // every point address used lies inside the store
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_addr < EXT_W'(MAX_POINTS)))
        else $error("control point read outside the store");

    // MAC step count never passes the last control point
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) || (r_state == S_ADD)) |-> (r_i <= I_LAST))
        else $error("MAC step count out of range");

    // an evaluate word starts the sequencer, a write word leaves it idle
    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_cmd == CMD_EVAL)) |=> (r_state == S_DIV))
        else $error("evaluate word did not start the sequencer");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_cmd == CMD_WRITE)) |=> (r_state == S_IDLE))
        else $error("write word left the idle state");

    // a bad-count result carries zero coordinates and segment
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_count) |->
            ((o_curve_x == '0) && (o_curve_y == '0) && (o_segment_index == '0)))
        else $error("bad-count result with nonzero fields");
`endif

endmodule

### sim/piecewise_bezier_evaluator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the piecewise Bezier evaluator: queued stimulus, exact predictor.
module piecewise_bezier_evaluator_test;
    import pbe_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    // Settling margin; it covers an evaluate word plus any trailing point write.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SUB_SHIFT = FRAC_BITS * ORDER;

    // One input word as it sits on the bus.
    typedef struct {
        logic                      cmd;
        logic [IDX_W-1:0]          index;
        logic signed [FIELD_W-1:0] px;
        logic signed [FIELD_W-1:0] py;
        logic signed [POS_W-1:0]   pos;
    } t_bez_word;

    // One curve sample as the block should return it.
    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [SEG_W-1:0]        seg;
        logic                    bad;
    } t_curve_point;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             cfg_ready;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      in_cmd = CMD_WRITE;
    logic [IDX_W-1:0]          in_index = '0;
    logic signed [FIELD_W-1:0] in_px = '0;
    logic signed [FIELD_W-1:0] in_py = '0;
    logic signed [POS_W-1:0]   in_pos = '0;

    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic [SEG_W-1:0]        out_seg;
    logic                    out_bad;

    // Words waiting for the driver, and curve samples waiting for the monitor.
    t_bez_word    word_q[$];
    t_curve_point curve_q[$];
    t_bez_word    held_word;

    // Predictor copy of the control-point store and of point_count.
    logic signed [COORD_WIDTH-1:0] pt_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] pt_y [MAX_POINTS];
    int unsigned                   count_model = 0;

    // Slots the generator has already filled; evaluations never touch anything else.
    bit slot_filled [MAX_POINTS];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycles = 0;

    piecewise_bezier_evaluator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (in_cmd),
        .i_point_index   (in_index),
        .i_point_x       (in_px),
        .i_point_y       (in_py),
        .i_curve_pos     (in_pos),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_curve_x       (out_x),
        .o_curve_y       (out_y),
        .o_segment_index (out_seg),
        .o_bad_count     (out_bad)
    );

    initial begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // Timeout guard.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycles, curve_q.size());
            $display("piecewise_bezier_evaluator_test failed");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("ERROR cycle %0d: %s", cycles, msg);
        error_count++;
    endtask

    // Exact Bernstein blend of one axis over ORDER+1 points from base, at sub-position s/2^16.
    // Weights C(m,i) * s^i * (2^16-s)^(m-i) stay below 2^50, so 96 bits hold the full sum.
    function automatic logic signed [OUT_W-1:0] blend_axis(input bit take_y,
                                                           input int unsigned base,
                                                           input int unsigned s);
        logic signed [95:0] acc;
        logic signed [95:0] wgt;
        logic signed [95:0] coord;
        logic [95:0]        mag;
        int unsigned        binom;
        acc = '0;
        binom = 1;
        for (int i = 0; i <= ORDER; i++) begin
            wgt = 96'(binom);
            for (int k = 0; k < i; k++) wgt = wgt * 96'(s);
            for (int k = i; k < ORDER; k++) wgt = wgt * 96'((1 << FRAC_BITS) - s);
            coord = take_y ? pt_y[base + i] : pt_x[base + i];
            acc = acc + wgt * coord;
            binom = binom * (ORDER - i) / (i + 1);
        end
        // round half away from zero on the magnitude
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + (96'd1 << (SUB_SHIFT - 1))) >> SUB_SHIFT;
        if (acc < 0) mag = -mag;
        return mag[OUT_W-1:0];
    endfunction

    // Layout choice, segment pick and blend for one evaluate word.
    function automatic t_curve_point predict_point(input logic [POS_W-1:0] pos);
        t_curve_point r;
        int unsigned  n;
        int unsigned  segs;
        int unsigned  stride;
        int unsigned  p;
        int unsigned  seg;
        n = count_model;
        segs = 0;
        stride = 0;
        r.x = '0;
        r.y = '0;
        r.seg = '0;
        r.bad = 1'b1;
        if (n >= 1 && n <= MAX_POINTS) begin
            // connected chain shares end points; a single cubic counts as separated
            if ((n - 1) != ORDER && (n - 1) % ORDER == 0) begin
                segs = (n - 1) / ORDER;
                stride = ORDER;
            end else if (n % (ORDER + 1) == 0) begin
                segs = n / (ORDER + 1);
                stride = ORDER + 1;
            end
        end
        if (segs != 0) begin
            // only the fraction of the position matters, so negatives wrap for free
            p = pos[FRAC_BITS-1:0] * segs;
            seg = p >> FRAC_BITS;
            r.x = blend_axis(1'b0, seg * stride, p & 16'hFFFF);
            r.y = blend_axis(1'b1, seg * stride, p & 16'hFFFF);
            r.seg = seg[SEG_W-1:0];
            r.bad = 1'b0;
        end
        return r;
    endfunction

    // Driver: a word leaves the bus on an edge with valid high and stall low.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (held_word.cmd == CMD_WRITE) begin
                    pt_x[held_word.index] = held_word.px;
                    pt_y[held_word.index] = held_word.py;
                end else begin
                    curve_q.push_back(predict_point(held_word.pos));
                end
            end
            // a stalled word stays put; otherwise load the next one or idle
            if (!in_valid || !in_stall) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_word = word_q.pop_front();
                    in_valid <= 1'b1;
                    in_cmd <= held_word.cmd;
                    in_index <= held_word.index;
                    in_px <= held_word.px;
                    in_py <= held_word.py;
                    in_pos <= held_word.pos;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every taken sample with the oldest prediction.
    always @(posedge clk) begin
        t_curve_point want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (curve_q.size() == 0) begin
                    flag_error($sformatf("unexpected sample x=%0d y=%0d seg=%0d bad=%0b",
                                         out_x, out_y, out_seg, out_bad));
                end else begin
                    want = curve_q.pop_front();
                    if (out_x !== want.x)
                        flag_error($sformatf("curve_x %0d, want %0d", out_x, want.x));
                    if (out_y !== want.y)
                        flag_error($sformatf("curve_y %0d, want %0d", out_y, want.y));
                    if (out_seg !== want.seg)
                        flag_error($sformatf("segment_index %0d, want %0d", out_seg, want.seg));
                    if (out_bad !== want.bad)
                        flag_error($sformatf("bad_count %0b, want %0b", out_bad, want.bad));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic queue_write(input int idx, input logic signed [FIELD_W-1:0] x,
                               input logic signed [FIELD_W-1:0] y);
        t_bez_word w;
        w.cmd = CMD_WRITE;
        w.index = idx[IDX_W-1:0];
        w.px = x;
        w.py = y;
        w.pos = POS_W'($urandom);
        word_q.push_back(w);
        slot_filled[idx] = 1'b1;
    endtask

    task automatic queue_eval(input logic signed [POS_W-1:0] pos);
        t_bez_word w;
        w.cmd = CMD_EVAL;
        w.index = IDX_W'($urandom);
        w.px = FIELD_W'($urandom);
        w.py = FIELD_W'($urandom);
        w.pos = pos;
        word_q.push_back(w);
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return FIELD_W'($urandom_range(16)) - 16'sd8;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Random position with extra weight on the wrap points and the half.
    function automatic logic signed [POS_W-1:0] pick_pos();
        logic [POS_W-1:0] pos;
        pos = POS_W'($urandom);
        case ($urandom_range(9))
            0: pos[FRAC_BITS-1:0] = '0;
            1: pos[FRAC_BITS-1:0] = '1;
            2: pos[FRAC_BITS-1:0] = 16'h8000;
            default: ;
        endcase
        return pos;
    endfunction

    // Fill every slot below n that no write has touched yet.
    task automatic cover_points(input int n);
        for (int i = 0; i < n; i++) begin
            if (!slot_filled[i]) queue_write(i, pick_coord(), pick_coord());
        end
    endtask

    // Block is idle once all words are taken, every sample is back and the pipe has drained.
    task automatic wait_idle();
        while (word_q.size() != 0 || in_valid || curve_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_point_count(input int n);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= n[CNT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_model = n;
    endtask

    task automatic random_phase(input int n, input int n_words);
        set_point_count(n);
        cover_points(n);
        repeat (n_words) begin
            if ($urandom_range(1)) queue_eval(pick_pos());
            else queue_write($urandom_range(MAX_POINTS - 1), pick_coord(), pick_coord());
        end
    endtask

    int phase_counts [10] = '{256, 10, 8, 0, 100, 252, 1, 4, 130, 2};

    initial begin
        send_idle_pct = 25;
        recv_stall_pct = 73;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single cubic, separated layout; P0 = (4,-4) puts both halves exactly on .5
        set_point_count(4);
        queue_write(0, 16'sd4, -16'sd4);
        queue_write(1, 16'sd0, 16'sd0);
        queue_write(2, 16'sd0, 16'sd0);
        queue_write(3, 16'sd0, 16'sd0);
        queue_eval(24'sh008000);
        queue_eval(24'sh000000);
        // full-scale corners, positions at both ends of the wrap
        queue_write(0, 16'sh8000, 16'sh7FFF);
        queue_write(1, 16'sh7FFF, 16'sh8000);
        queue_write(2, 16'sh8000, 16'sh8000);
        queue_write(3, 16'sh7FFF, 16'sh7FFF);
        queue_eval(24'sh7FFFFF);
        queue_eval(24'sh800000);
        queue_eval(24'shFF0000);
        queue_eval(24'sh00FFFF);
        queue_eval(24'shFF8000);

        // two connected segments; the half lands on the shared end point
        set_point_count(7);
        cover_points(7);
        queue_eval(24'sh008000);
        queue_eval(24'sh007FFF);

        // counts with no layout: empty, single point, fits neither
        set_point_count(0);
        queue_eval(24'sh001234);
        set_point_count(1);
        queue_eval(24'sh00C000);
        set_point_count(5);
        queue_eval(24'sh004000);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 4) begin
                wait_idle();
                send_idle_pct = 73;
                recv_stall_pct = 25;
            end else if (ph == 7) begin
                wait_idle();
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            random_phase(phase_counts[ph], 125);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("piecewise_bezier_evaluator_test passed");
        end else begin
            $display("piecewise_bezier_evaluator_test failed");
        end
        $finish;
    end

endmodule

### piecewise_bezier_evaluator.f
design/pbe_pkg.sv
design/pbe_ram.sv
design/piecewise_bezier_evaluator.sv
sim/piecewise_bezier_evaluator_test.sv
